/* design/foc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// foc_pkg
// Shared types, operation codes and Q15 coefficients of the frame transform unit.
// ----------------------------------------------------------------------------
package foc_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int FUNC_WIDTH  = 2;
  localparam int FRAC_BITS   = 15;
  localparam int COEF_WIDTH  = FRAC_BITS + 2;
  localparam int PROD_WIDTH  = DATA_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;

  localparam logic [FUNC_WIDTH-1:0] FUNC_CLARKE       = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_PARK         = 2'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_INV_PARK     = 2'd2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_INV_CLARKE   = 2'd3;

  localparam logic signed [COEF_WIDTH-1:0] C_ZERO           = 17'sd0;
  localparam logic signed [COEF_WIDTH-1:0] C_TWO_THIRDS     = 17'sd21845;
  localparam logic signed [COEF_WIDTH-1:0] C_NEG_THIRD      = -17'sd10923;
  localparam logic signed [COEF_WIDTH-1:0] C_INV_SQRT3      = 17'sd18919;
  localparam logic signed [COEF_WIDTH-1:0] C_NEG_INV_SQRT3  = -17'sd18919;
  localparam logic signed [COEF_WIDTH-1:0] C_NEG_HALF       = -17'sd16384;
  localparam logic signed [COEF_WIDTH-1:0] C_HALF_SQRT3     = 17'sd28378;
  localparam logic signed [COEF_WIDTH-1:0] C_NEG_HALF_SQRT3 = -17'sd28378;
  localparam logic signed [COEF_WIDTH-1:0] C_ONE            = 17'sd32768;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [FUNC_WIDTH-1:0]        func;
    logic signed [DATA_WIDTH-1:0] in_a;
    logic signed [DATA_WIDTH-1:0] in_b;
    logic signed [DATA_WIDTH-1:0] in_c;
    logic [ANGLE_WIDTH-1:0]       angle;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_a;
    logic signed [DATA_WIDTH-1:0] out_b;
    logic signed [DATA_WIDTH-1:0] out_c;
    logic                         saturated;
  } out_t;

  // coefficients applied to the a, b and c operands for one result component
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] ka;
    logic signed [COEF_WIDTH-1:0] kb;
    logic signed [COEF_WIDTH-1:0] kc;
  } row_t;

  typedef struct packed {
    row_t ra;
    row_t rb;
    row_t rc;
  } mat_t;

endpackage
`default_nettype wire

/* design/foc_frame_transform_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// foc_frame_transform_unit
// Clarke, Park, inverse Park and inverse Clarke transforms on Q1.15 data.
// ----------------------------------------------------------------------------
// out_valid rises once the accepted input transaction has passed through stage 1 and stage 2 into stage 3
// throughput: one transaction per cycle while out_ready holds high, three register stages with per-stage ready
// stage 1 holds the input, stage 2 the sine table read and coefficients,
// stage 3 the rounded and saturated results
// reset: synchronous, active low, clears the stage valid flags only
module foc_frame_transform_unit #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire foc_pkg::in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output foc_pkg::out_t out_data
);

  logic          v1_r, v1_nxt;
  foc_pkg::in_t  d1_r, d1_nxt;
  logic          v2_r, v2_nxt;
  logic signed [foc_pkg::DATA_WIDTH-1:0] a2_r, a2_nxt;
  logic signed [foc_pkg::DATA_WIDTH-1:0] b2_r, b2_nxt;
  logic signed [foc_pkg::DATA_WIDTH-1:0] c2_r, c2_nxt;
  foc_pkg::mat_t coef2_r, coef2_nxt;
  logic          v3_r, v3_nxt;
  foc_pkg::out_t q3_r, q3_nxt;

  logic          adv3;
  logic          rdy2;
  logic          rdy1;
  logic signed [foc_pkg::COEF_WIDTH-1:0] sin_w;
  logic signed [foc_pkg::COEF_WIDTH-1:0] cos_w;
  foc_pkg::mat_t coef_w;
  foc_pkg::out_t res_w;
  logic signed [foc_pkg::DATA_WIDTH-1:0] res_a_w;
  logic signed [foc_pkg::DATA_WIDTH-1:0] res_b_w;
  logic signed [foc_pkg::DATA_WIDTH-1:0] res_c_w;
  logic [2:0]    clip_w;

  foc_sincos #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sincos (
    .angle   (d1_r.angle),
    .sin_val (sin_w),
    .cos_val (cos_w)
  );

  foc_coef u_coef (
    .func    (d1_r.func),
    .sin_val (sin_w),
    .cos_val (cos_w),
    .coef    (coef_w)
  );

  foc_mac u_mac_a (
    .x_a  (a2_r),
    .x_b  (b2_r),
    .x_c  (c2_r),
    .k    (coef2_r.ra),
    .y    (res_a_w),
    .clip (clip_w[0])
  );

  foc_mac u_mac_b (
    .x_a  (a2_r),
    .x_b  (b2_r),
    .x_c  (c2_r),
    .k    (coef2_r.rb),
    .y    (res_b_w),
    .clip (clip_w[1])
  );

  foc_mac u_mac_c (
    .x_a  (a2_r),
    .x_b  (b2_r),
    .x_c  (c2_r),
    .k    (coef2_r.rc),
    .y    (res_c_w),
    .clip (clip_w[2])
  );

  assign res_w = '{res_a_w, res_b_w, res_c_w, |clip_w};

  always_comb begin
    adv3      = !v3_r || out_ready;
    rdy2      = !v2_r || adv3;
    rdy1      = !v1_r || rdy2;
    in_ready  = rdy1;

    v1_nxt    = rdy1 ? in_valid : v1_r;
    d1_nxt    = (rdy1 && in_valid) ? in_data : d1_r;

    v2_nxt    = rdy2 ? v1_r : v2_r;
    a2_nxt    = a2_r;
    b2_nxt    = b2_r;
    c2_nxt    = c2_r;
    coef2_nxt = coef2_r;
    if (rdy2 && v1_r) begin
      a2_nxt    = d1_r.in_a;
      b2_nxt    = d1_r.in_b;
      c2_nxt    = d1_r.in_c;
      coef2_nxt = coef_w;
    end

    v3_nxt    = adv3 ? v2_r : v3_r;
    q3_nxt    = (adv3 && v2_r) ? res_w : q3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d1_r    <= d1_nxt;
    a2_r    <= a2_nxt;
    b2_r    <= b2_nxt;
    c2_r    <= c2_nxt;
    coef2_r <= coef2_nxt;
    q3_r    <= q3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = q3_r;

  // a flagged result has at least one component on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_a == foc_pkg::DATA_MAX || out_data.out_a == foc_pkg::DATA_MIN ||
       out_data.out_b == foc_pkg::DATA_MAX || out_data.out_b == foc_pkg::DATA_MIN ||
       out_data.out_c == foc_pkg::DATA_MAX || out_data.out_c == foc_pkg::DATA_MIN))
    else $error("saturated flag without a clipped component");

  // full pipeline with a stalled output must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline full and stalled");

  // a stage 2 transaction moves into the output register when it advances
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv3) |=> out_valid)
    else $error("transaction lost between stage 2 and output");

  // a stalled output register keeps its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(q3_r)))
    else $error("output transaction dropped while stalled");

endmodule
`default_nettype wire

/* design/foc_sincos.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// foc_sincos
// Quarter-wave sine table with quadrant folding, giving Q15 sine and cosine.
// ----------------------------------------------------------------------------
module foc_sincos #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  wire logic [foc_pkg::ANGLE_WIDTH-1:0]       angle,
  output logic signed [foc_pkg::COEF_WIDTH-1:0]      sin_val,
  output logic signed [foc_pkg::COEF_WIDTH-1:0]      cos_val
);

  localparam int N  = 1 << SINE_TABLE_BITS;
  localparam int IW = SINE_TABLE_BITS + 1;
  localparam int MW = foc_pkg::COEF_WIDTH - 1;

  // sin(k*pi/(2N)) in q30 by taylor series, rounded to q15
  function automatic logic [MW-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (64'(k) * 64'd1686629713) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    acc  = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + $signed(term);
    if (acc < 0) begin
      return '0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    return acc[MW-1:0];
  endfunction

  logic [MW-1:0] rom_w [0:N];

  for (genvar k = 0; k <= N; k++) begin : g_rom
    assign rom_w[k] = sine_entry(k);
  end

  logic [1:0]                      sin_quad;
  logic [1:0]                      cos_quad;
  logic [IW-1:0]                   idx_fwd;
  logic [IW-1:0]                   idx_rev;
  logic signed [foc_pkg::COEF_WIDTH-1:0] sin_mag;
  logic signed [foc_pkg::COEF_WIDTH-1:0] cos_mag;

  always_comb begin
    sin_quad = angle[foc_pkg::ANGLE_WIDTH-1 -: 2];
    cos_quad = sin_quad + 2'd1;
    idx_fwd  = {1'b0, angle[foc_pkg::ANGLE_WIDTH-3 -: SINE_TABLE_BITS]};
    idx_rev  = IW'(N) - idx_fwd;
    sin_mag  = sin_quad[0] ? $signed({1'b0, rom_w[idx_rev]}) : $signed({1'b0, rom_w[idx_fwd]});
    cos_mag  = cos_quad[0] ? $signed({1'b0, rom_w[idx_rev]}) : $signed({1'b0, rom_w[idx_fwd]});
    sin_val  = sin_quad[1] ? -sin_mag : sin_mag;
    cos_val  = cos_quad[1] ? -cos_mag : cos_mag;
  end

endmodule
`default_nettype wire

/* design/foc_coef.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// foc_coef
// Builds the 3x3 Q15 coefficient matrix for the selected transform.
// ----------------------------------------------------------------------------
module foc_coef (
  input  wire logic [foc_pkg::FUNC_WIDTH-1:0]         func,
  input  wire logic signed [foc_pkg::COEF_WIDTH-1:0]  sin_val,
  input  wire logic signed [foc_pkg::COEF_WIDTH-1:0]  cos_val,
  output foc_pkg::mat_t                               coef
);

  logic signed [foc_pkg::COEF_WIDTH-1:0] neg_sin;

  always_comb begin
    neg_sin = -sin_val;
    coef    = '0;
    case (func)
      foc_pkg::FUNC_CLARKE: begin
        coef.ra = '{foc_pkg::C_TWO_THIRDS, foc_pkg::C_NEG_THIRD, foc_pkg::C_NEG_THIRD};
        coef.rb = '{foc_pkg::C_ZERO, foc_pkg::C_INV_SQRT3, foc_pkg::C_NEG_INV_SQRT3};
      end
      foc_pkg::FUNC_PARK: begin
        coef.ra = '{cos_val, sin_val, foc_pkg::C_ZERO};
        coef.rb = '{neg_sin, cos_val, foc_pkg::C_ZERO};
      end
      foc_pkg::FUNC_INV_PARK: begin
        coef.ra = '{cos_val, neg_sin, foc_pkg::C_ZERO};
        coef.rb = '{sin_val, cos_val, foc_pkg::C_ZERO};
      end
      foc_pkg::FUNC_INV_CLARKE: begin
        coef.ra = '{foc_pkg::C_ONE, foc_pkg::C_ZERO, foc_pkg::C_ZERO};
        coef.rb = '{foc_pkg::C_NEG_HALF, foc_pkg::C_HALF_SQRT3, foc_pkg::C_ZERO};
        coef.rc = '{foc_pkg::C_NEG_HALF, foc_pkg::C_NEG_HALF_SQRT3, foc_pkg::C_ZERO};
      end
      default: begin
        coef = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/foc_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// foc_mac
// Three-term Q15 dot product with round to nearest and saturation.
// ----------------------------------------------------------------------------
module foc_mac (
  input  wire logic signed [foc_pkg::DATA_WIDTH-1:0]  x_a,
  input  wire logic signed [foc_pkg::DATA_WIDTH-1:0]  x_b,
  input  wire logic signed [foc_pkg::DATA_WIDTH-1:0]  x_c,
  input  wire foc_pkg::row_t                          k,
  output logic signed [foc_pkg::DATA_WIDTH-1:0]       y,
  output logic                                        clip
);

  localparam int PW = foc_pkg::PROD_WIDTH;
  localparam int AW = foc_pkg::ACC_WIDTH;
  localparam int RW = AW - foc_pkg::FRAC_BITS;
  localparam logic signed [AW-1:0] HALF_LSB = AW'(1) <<< (foc_pkg::FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_MAX =
    {{(RW-foc_pkg::DATA_WIDTH+1){1'b0}}, {(foc_pkg::DATA_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PW-1:0] p_a;
  logic signed [PW-1:0] p_b;
  logic signed [PW-1:0] p_c;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] rnd;

  always_comb begin
    p_a  = PW'(k.ka) * PW'(x_a);
    p_b  = PW'(k.kb) * PW'(x_b);
    p_c  = PW'(k.kc) * PW'(x_c);
    acc  = AW'(p_a) + AW'(p_b) + AW'(p_c) + HALF_LSB;
    rnd  = acc[AW-1:foc_pkg::FRAC_BITS];
    clip = 1'b0;
    y    = rnd[foc_pkg::DATA_WIDTH-1:0];
    if (rnd > SAT_MAX) begin
      y    = foc_pkg::DATA_MAX;
      clip = 1'b1;
    end else if (rnd < SAT_MIN) begin
      y    = foc_pkg::DATA_MIN;
      clip = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_foc_frame_transform_unit.sv */
// ----------------------------------------------------------------------------
// tb_foc_frame_transform_unit
// Self-checking bench for the Clarke, Park, inverse Park and inverse Clarke
// unit. A directed table covers the operand extremes, quadrant edges and
// saturation, then random transactions run against a bit-accurate Q15 model
// of the transforms with a Taylor-built quarter-wave sine table. The sender
// works in bursts and the receiver stalls on its own pattern, including one
// long hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_foc_frame_transform_unit;

  localparam int CLK_PERIOD   = 10;
  localparam int TABLE_BITS   = 8;
  localparam int ROM_N        = 1 << TABLE_BITS;
  localparam int RANDOM_ITEMS = 1130;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_AT     = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 8;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam longint K_TWO_THIRDS   = foc_pkg::C_TWO_THIRDS;
  localparam longint K_NEG_THIRD    = foc_pkg::C_NEG_THIRD;
  localparam longint K_INV_SQRT3    = foc_pkg::C_INV_SQRT3;
  localparam longint K_NEG_HALF     = foc_pkg::C_NEG_HALF;
  localparam longint K_HALF_SQRT3   = foc_pkg::C_HALF_SQRT3;
  localparam longint K_ONE          = foc_pkg::C_ONE;
  localparam longint RESULT_MAX     = foc_pkg::DATA_MAX;
  localparam longint RESULT_MIN     = foc_pkg::DATA_MIN;

  localparam logic [foc_pkg::FUNC_WIDTH-1:0] F_CLARKE     = foc_pkg::FUNC_CLARKE;
  localparam logic [foc_pkg::FUNC_WIDTH-1:0] F_PARK       = foc_pkg::FUNC_PARK;
  localparam logic [foc_pkg::FUNC_WIDTH-1:0] F_INV_PARK   = foc_pkg::FUNC_INV_PARK;
  localparam logic [foc_pkg::FUNC_WIDTH-1:0] F_INV_CLARKE = foc_pkg::FUNC_INV_CLARKE;

  typedef struct packed {
    logic          fixed;
    foc_pkg::out_t value;
  } known_result_t;

  typedef struct packed {
    foc_pkg::in_t  item;
    logic          fixed;
    foc_pkg::out_t value;
  } directed_row_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  foc_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  foc_pkg::out_t out_data;

  longint        sine_rom [0:ROM_N];
  foc_pkg::out_t pending_results [$];
  known_result_t fixed_results [$];
  directed_row_t directed_rows [$];
  int            fail_count = 0;
  int            idle_cycles = 0;
  bit            hold_req = 1'b0;

  foc_frame_transform_unit #(
    .SINE_TABLE_BITS(TABLE_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sin(k*pi/(2N)) in Q30 by truncated Taylor terms, rounded to Q15
  function automatic longint sine_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    x = k;
    x = (x * HALF_PI_Q30) >> TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      return 0;
    end
    return (acc + 16384) >>> 15;
  endfunction

  function automatic longint sine_of(input logic [15:0] ang);
    int unsigned idx;
    longint v;
    idx = (ang >> (14 - TABLE_BITS)) & (ROM_N - 1);
    v = ang[14] ? sine_rom[ROM_N - idx] : sine_rom[idx];
    return ang[15] ? -v : v;
  endfunction

  function automatic logic [15:0] round_clip(input longint acc, inout logic sat);
    longint r;
    r = (acc + 64'sd16384) >>> foc_pkg::FRAC_BITS;
    if (r > RESULT_MAX) begin
      r = RESULT_MAX;
      sat = 1'b1;
    end
    if (r < RESULT_MIN) begin
      r = RESULT_MIN;
      sat = 1'b1;
    end
    return r[15:0];
  endfunction

  function automatic foc_pkg::out_t transform(input foc_pkg::in_t t);
    longint a;
    longint b;
    longint c;
    longint s;
    longint co;
    logic [15:0] cos_angle;
    logic sat;
    foc_pkg::out_t r;
    a = longint'($signed(t.in_a));
    b = longint'($signed(t.in_b));
    c = longint'($signed(t.in_c));
    cos_angle = t.angle + 16'd16384;
    s = sine_of(t.angle);
    co = sine_of(cos_angle);
    sat = 1'b0;
    r = '0;
    case (t.func)
      F_CLARKE: begin
        r.out_a = round_clip(K_TWO_THIRDS * a + K_NEG_THIRD * b + K_NEG_THIRD * c, sat);
        r.out_b = round_clip(K_INV_SQRT3 * b - K_INV_SQRT3 * c, sat);
      end
      F_PARK: begin
        r.out_a = round_clip(co * a + s * b, sat);
        r.out_b = round_clip(co * b - s * a, sat);
      end
      F_INV_PARK: begin
        r.out_a = round_clip(co * a - s * b, sat);
        r.out_b = round_clip(s * a + co * b, sat);
      end
      default: begin
        r.out_a = round_clip(K_ONE * a, sat);
        r.out_b = round_clip(K_NEG_HALF * a + K_HALF_SQRT3 * b, sat);
        r.out_c = round_clip(K_NEG_HALF * a - K_HALF_SQRT3 * b, sat);
      end
    endcase
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return foc_pkg::DATA_MAX;
      1: return foc_pkg::DATA_MIN;
      2: return '0;
      3: return '1;
      4: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic foc_pkg::in_t random_item();
    foc_pkg::in_t t;
    t.func = 2'($urandom_range(0, 3));
    t.in_a = pick_operand();
    t.in_b = pick_operand();
    t.in_c = pick_operand();
    if ($urandom_range(0, 9) < 3) begin
      t.angle = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 127)) - 16'd64;
    end else begin
      t.angle = 16'($urandom());
    end
    return t;
  endfunction

  task automatic add_row(input logic [1:0] f, input int a, input int b, input int c,
                         input int ang, input bit fixed, input int oa, input int ob,
                         input int oc, input bit sat);
    directed_row_t r;
    r.item.func = f;
    r.item.in_a = a[15:0];
    r.item.in_b = b[15:0];
    r.item.in_c = c[15:0];
    r.item.angle = ang[15:0];
    r.fixed = fixed;
    r.value.out_a = oa[15:0];
    r.value.out_b = ob[15:0];
    r.value.out_c = oc[15:0];
    r.value.saturated = sat;
    directed_rows.push_back(r);
  endtask

  task automatic offer(input foc_pkg::in_t item, input logic fixed,
                       input foc_pkg::out_t value);
    fixed_results.push_back('{fixed, value});
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d (0x%h) actual %0d (0x%h)", $time, name,
               $signed(want), want, $signed(got), got);
      fail_count++;
    end
  endtask

  // scoreboard: expectation on each input transaction, compare on each output one
  always @(posedge clk) begin : scoreboard
    known_result_t known;
    foc_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        known = fixed_results.pop_front();
        pending_results.push_back(known.fixed ? known.value : transform(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_a", want.out_a, out_data.out_a);
          check_field("out_b", want.out_b, out_data.out_b);
          check_field("out_c", want.out_c, out_data.out_c);
          check_field("saturated", 16'(want.saturated), 16'(out_data.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t timeout with %0d results outstanding", $time,
                 pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: stall pattern changes per stretch, plus one long hold-off
  initial begin : receiver
    int mode;
    int span;
    int phase;
    mode = 0;
    span = 0;
    phase = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 100);
        end
        span--;
        phase++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (phase % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : sender
    int gap;
    int burst_left;
    for (int k = 0; k <= ROM_N; k++) begin
      sine_rom[k] = sine_entry(k);
    end

    // func, a, b, c, angle, fixed, out_a, out_b, out_c, saturated
    add_row(F_CLARKE,         0,      0,      0,      0, 1,      0,      0,      0, 0);
    add_row(F_CLARKE,     32767, -32768, -32768,      0, 1,  32767,      0,      0, 1);
    add_row(F_CLARKE,    -32768,  32767,  32767,      0, 1, -32768,      0,      0, 1);
    add_row(F_CLARKE,         0,  32767, -32768,      0, 1,      0,  32767,      0, 1);
    add_row(F_CLARKE,      1000,   1000,   1000, 'hffff, 1,      0,      0,      0, 0);
    add_row(F_CLARKE,     12345,  -7000,    333, 'h1234, 0,      0,      0,      0, 0);
    add_row(F_INV_CLARKE, 32767,      0,      0,      0, 1,  32767, -16383, -16383, 0);
    add_row(F_INV_CLARKE,-32768, -32768,      0,      0, 1, -32768, -11994,  32767, 1);
    add_row(F_INV_CLARKE,     0,      0,     -1, 'hffff, 1,      0,      0,      0, 0);
    add_row(F_INV_CLARKE,     1,      0,      0,      0, 0,      0,      0,      0, 0);
    add_row(F_INV_CLARKE,    -1,  32767, -32768, 'h8000, 0,      0,      0,      0, 0);
    add_row(F_PARK,       12345,  -5432,      0,      0, 1,  12345,  -5432,      0, 0);
    add_row(F_PARK,       12345,  -5432,      0, 'h4000, 1,  -5432, -12345,      0, 0);
    add_row(F_PARK,      -32768, -32768,      0, 'h2000, 0,      0,      0,      0, 0);
    add_row(F_PARK,       20000,  30000,     -1, 'hc000, 0,      0,      0,      0, 0);
    add_row(F_PARK,       32767,  32767,      0, 'hffff, 0,      0,      0,      0, 0);
    add_row(F_PARK,       32767,  -3000,      0, 'h003f, 0,      0,      0,      0, 0);
    add_row(F_INV_PARK,  -20000,  30000,      0,      0, 1, -20000,  30000,      0, 0);
    add_row(F_INV_PARK,  -32768,  32767,      0, 'h8000, 1,  32767, -32767,      0, 1);
    add_row(F_INV_PARK,   32767,  32767,  32767, 'h6000, 0,      0,      0,      0, 0);
    add_row(F_INV_PARK,  -32768,  32767,      0, 'h7fc0, 0,      0,      0,      0, 0);
    add_row(F_INV_PARK,   -4321,  -1234,      0, 'h4040, 0,      0,      0,      0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pause($urandom_range(0, 2));
      offer(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].value);
    end

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) begin
        hold_req = 1'b1;
        burst_left = 40;
      end else if (i == DRAIN_AT) begin
        drain_results();
        burst_left = 0;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        pause(gap);
      end
      burst_left--;
      offer(random_item(), 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
